// ===== rtl/cclt_pkg.sv =====
// Shared types and constants for the calendar content line tokenizer.
package cclt_pkg;

  typedef enum logic [3:0] {
    M_NORMAL   = 4'd0,
    M_CR       = 4'd1,
    M_LF       = 4'd2,
    M_ESC      = 4'd3,
    M_ESC_CR   = 4'd4,
    M_ESC_LF   = 4'd5,
    M_ESC_FOLD = 4'd6,
    M_HALT     = 4'd7
  } mode_t;

  typedef enum logic [1:0] {
    P_KEY   = 2'd0,
    P_PNAME = 2'd1,
    P_PVAL  = 2'd2,
    P_VALUE = 2'd3
  } part_t;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_KEY   = 3'd1;
  localparam logic [2:0] EV_PNAME = 3'd2;
  localparam logic [2:0] EV_PVAL  = 3'd3;
  localparam logic [2:0] EV_LINE  = 3'd4;

  localparam logic [1:0] KIND_ORD   = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CR    = 2'd1;
  localparam logic [1:0] ERR_ESC   = 2'd2;
  localparam logic [1:0] ERR_FATAL = 2'd3;

  // key prefix tracker codes
  localparam logic [3:0] KM_EMPTY = 4'd0;
  localparam logic [3:0] KM_B     = 4'd1;
  localparam logic [3:0] KM_BE    = 4'd2;
  localparam logic [3:0] KM_BEG   = 4'd3;
  localparam logic [3:0] KM_BEGI  = 4'd4;
  localparam logic [3:0] KM_BEGIN = 4'd5;
  localparam logic [3:0] KM_E     = 4'd6;
  localparam logic [3:0] KM_EN    = 4'd7;
  localparam logic [3:0] KM_END   = 4'd8;
  localparam logic [3:0] KM_MISS  = 4'd9;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_UI    = 8'h49;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_LN    = 8'h6E;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic [1:0] role;
    logic [2:0] event_res;
    logic [1:0] next_part;
    logic [1:0] line_kind;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  // results caused by one transaction: count 0..2, in order r0 then r1
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_res_t;

endpackage

// ===== rtl/cclt_in_if.sv =====
// Input byte channel interface.
interface cclt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/cclt_out_if.sv =====
// Result channel interface.
interface cclt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic [1:0] role;
  logic [2:0] event_res;
  logic [1:0] next_part;
  logic [1:0] line_kind;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output out_char, output char_valid, output role,
                  output event_res, output next_part, output line_kind,
                  output error_code, output last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input role,
                  input event_res, input next_part, input line_kind,
                  input error_code, input last, output ready);
endinterface

// ===== rtl/cclt_lexer.sv =====
// Lexer state registers and the per-byte step logic producing up to two results.
module cclt_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                end_of_stream,
  output cclt_pkg::step_res_t step
);

  typedef struct packed {
    cclt_pkg::mode_t mode;
    cclt_pkg::part_t part;
    logic [3:0]      km;
    logic [1:0]      lkc;
    logic [1:0]      n;
    cclt_pkg::res_t  r0;
    cclt_pkg::res_t  r1;
  } lx_t;

  cclt_pkg::mode_t mode_r, mode_nxt;
  cclt_pkg::part_t part_r, part_nxt;
  logic [3:0]      km_r, km_nxt;
  logic [1:0]      lkc_r, lkc_nxt;

  function automatic logic [3:0] match_step(logic [3:0] m, logic [7:0] c);
    logic [3:0] r;
    r = cclt_pkg::KM_MISS;
    unique case (m)
      cclt_pkg::KM_EMPTY: r = (c == cclt_pkg::CH_UB) ? cclt_pkg::KM_B :
                              ((c == cclt_pkg::CH_UE) ? cclt_pkg::KM_E : cclt_pkg::KM_MISS);
      cclt_pkg::KM_B:    if (c == cclt_pkg::CH_UE) r = cclt_pkg::KM_BE;
      cclt_pkg::KM_BE:   if (c == cclt_pkg::CH_UG) r = cclt_pkg::KM_BEG;
      cclt_pkg::KM_BEG:  if (c == cclt_pkg::CH_UI) r = cclt_pkg::KM_BEGI;
      cclt_pkg::KM_BEGI: if (c == cclt_pkg::CH_UN) r = cclt_pkg::KM_BEGIN;
      cclt_pkg::KM_E:    if (c == cclt_pkg::CH_UN) r = cclt_pkg::KM_EN;
      cclt_pkg::KM_EN:   if (c == cclt_pkg::CH_UD) r = cclt_pkg::KM_END;
      default:           r = cclt_pkg::KM_MISS;
    endcase
    return r;
  endfunction

  function automatic cclt_pkg::res_t mk_res(logic [7:0] ch, logic vld, logic [1:0] role,
                                            logic [2:0] ev, logic [1:0] nxt,
                                            logic [1:0] kind, logic [1:0] err);
    cclt_pkg::res_t r;
    r.out_char   = ch;
    r.char_valid = vld;
    r.role       = role;
    r.event_res  = ev;
    r.next_part  = nxt;
    r.line_kind  = kind;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic lx_t put_res(lx_t s, cclt_pkg::res_t r);
    lx_t o;
    o = s;
    if (s.n == 2'd0) o.r0 = r;
    else             o.r1 = r;
    o.n = s.n + 2'd1;
    return o;
  endfunction

  function automatic lx_t emit_char(lx_t s, logic [7:0] c, logic [1:0] err);
    lx_t o;
    o = s;
    if (s.part == cclt_pkg::P_KEY) o.km = match_step(s.km, c);
    o = put_res(o, mk_res(c, 1'b1, s.part, cclt_pkg::EV_NONE, s.part,
                          cclt_pkg::KIND_ORD, err));
    return o;
  endfunction

  function automatic lx_t line_end(lx_t s);
    lx_t o;
    o = put_res(s, mk_res(8'd0, 1'b0, s.part, cclt_pkg::EV_LINE, cclt_pkg::P_KEY,
                          s.lkc, cclt_pkg::ERR_NONE));
    o.part = cclt_pkg::P_KEY;
    o.km   = cclt_pkg::KM_EMPTY;
    return o;
  endfunction

  function automatic lx_t status_res(lx_t s, logic [1:0] err);
    return put_res(s, mk_res(8'd0, 1'b0, s.part, cclt_pkg::EV_NONE, s.part,
                             cclt_pkg::KIND_ORD, err));
  endfunction

  function automatic lx_t fatal(lx_t s);
    lx_t o;
    o = status_res(s, cclt_pkg::ERR_FATAL);
    o.mode = cclt_pkg::M_HALT;
    return o;
  endfunction

  function automatic lx_t normal_byte(lx_t s, logic [7:0] c);
    lx_t             o;
    cclt_pkg::part_t nxt;
    logic [2:0]      ev;
    o   = s;
    nxt = (c == cclt_pkg::CH_COLON) ? cclt_pkg::P_VALUE : cclt_pkg::P_PNAME;
    ev  = (s.part == cclt_pkg::P_KEY) ? cclt_pkg::EV_KEY : cclt_pkg::EV_PVAL;
    if (c == cclt_pkg::CH_CR) begin
      o.mode = cclt_pkg::M_CR;
    end else if (c == cclt_pkg::CH_LF) begin
      o.mode = cclt_pkg::M_LF;
    end else if (c == cclt_pkg::CH_BSL) begin
      o.mode = cclt_pkg::M_ESC;
    end else if (s.part == cclt_pkg::P_PNAME && c == cclt_pkg::CH_EQ) begin
      o = put_res(o, mk_res(8'd0, 1'b0, cclt_pkg::P_PNAME, cclt_pkg::EV_PNAME,
                            cclt_pkg::P_PVAL, cclt_pkg::KIND_ORD, cclt_pkg::ERR_NONE));
      o.part = cclt_pkg::P_PVAL;
    end else if ((s.part == cclt_pkg::P_KEY || s.part == cclt_pkg::P_PVAL) &&
                 (c == cclt_pkg::CH_COLON || c == cclt_pkg::CH_SEMI)) begin
      if (s.part == cclt_pkg::P_KEY) begin
        o.lkc = (s.km == cclt_pkg::KM_BEGIN) ? cclt_pkg::KIND_BEGIN :
                ((s.km == cclt_pkg::KM_END) ? cclt_pkg::KIND_END : cclt_pkg::KIND_ORD);
        o.km  = cclt_pkg::KM_EMPTY;
      end
      o = put_res(o, mk_res(8'd0, 1'b0, s.part, ev, nxt, cclt_pkg::KIND_ORD,
                            cclt_pkg::ERR_NONE));
      o.part = nxt;
    end else begin
      o = emit_char(o, c, cclt_pkg::ERR_NONE);
    end
    return o;
  endfunction

  function automatic lx_t escaped_byte(lx_t s, logic [7:0] c);
    lx_t o;
    o      = s;
    o.mode = cclt_pkg::M_NORMAL;
    if (c == cclt_pkg::CH_LN || c == cclt_pkg::CH_UN)
      o = emit_char(o, cclt_pkg::CH_LF, cclt_pkg::ERR_NONE);
    else if (c == cclt_pkg::CH_SEMI || c == cclt_pkg::CH_COMMA || c == cclt_pkg::CH_BSL)
      o = emit_char(o, c, cclt_pkg::ERR_NONE);
    else
      o = emit_char(o, c, cclt_pkg::ERR_ESC);
    return o;
  endfunction

  lx_t s;

  always_comb begin
    s.mode = mode_r;
    s.part = part_r;
    s.km   = km_r;
    s.lkc  = lkc_r;
    s.n    = 2'd0;
    s.r0   = '0;
    s.r1   = '0;
    if (mode_r == cclt_pkg::M_HALT) begin
      // halted: swallow everything until reset
    end else if (end_of_stream) begin
      case (mode_r)
        cclt_pkg::M_LF:                         s = line_end(s);
        cclt_pkg::M_CR:                         s = status_res(s, cclt_pkg::ERR_CR);
        cclt_pkg::M_ESC, cclt_pkg::M_ESC_FOLD:  s = status_res(s, cclt_pkg::ERR_ESC);
        cclt_pkg::M_ESC_CR, cclt_pkg::M_ESC_LF: s = fatal(s);
        default: ;
      endcase
      if (s.mode != cclt_pkg::M_HALT) begin
        s.mode = cclt_pkg::M_NORMAL;
        s.part = cclt_pkg::P_KEY;
        s.km   = cclt_pkg::KM_EMPTY;
      end
    end else begin
      unique case (mode_r)
        cclt_pkg::M_CR: begin
          if (data_byte == cclt_pkg::CH_LF) begin
            s.mode = cclt_pkg::M_LF;
          end else begin
            s      = status_res(s, cclt_pkg::ERR_CR);
            s.mode = cclt_pkg::M_NORMAL;
            s      = normal_byte(s, data_byte);
          end
        end
        cclt_pkg::M_LF: begin
          s.mode = cclt_pkg::M_NORMAL;
          if (data_byte != cclt_pkg::CH_SPACE && data_byte != cclt_pkg::CH_TAB) begin
            s = line_end(s);
            s = normal_byte(s, data_byte);
          end
        end
        cclt_pkg::M_ESC: begin
          if (data_byte == cclt_pkg::CH_CR)      s.mode = cclt_pkg::M_ESC_CR;
          else if (data_byte == cclt_pkg::CH_LF) s.mode = cclt_pkg::M_ESC_LF;
          else                                   s = escaped_byte(s, data_byte);
        end
        cclt_pkg::M_ESC_CR: begin
          if (data_byte == cclt_pkg::CH_LF) s.mode = cclt_pkg::M_ESC_LF;
          else                              s = fatal(s);
        end
        cclt_pkg::M_ESC_LF: begin
          if (data_byte == cclt_pkg::CH_SPACE || data_byte == cclt_pkg::CH_TAB)
            s.mode = cclt_pkg::M_ESC_FOLD;
          else
            s = fatal(s);
        end
        cclt_pkg::M_ESC_FOLD: s = escaped_byte(s, data_byte);
        default: begin
          s.mode = cclt_pkg::M_NORMAL;
          s      = normal_byte(s, data_byte);
        end
      endcase
    end
    if (s.n == 2'd1) s.r0.last = 1'b1;
    if (s.n == 2'd2) s.r1.last = 1'b1;
  end

  assign step.cnt = s.n;
  assign step.r0  = s.r0;
  assign step.r1  = s.r1;

  always_comb begin
    mode_nxt = mode_r;
    part_nxt = part_r;
    km_nxt   = km_r;
    lkc_nxt  = lkc_r;
    if (take) begin
      mode_nxt = s.mode;
      part_nxt = s.part;
      km_nxt   = s.km;
      lkc_nxt  = s.lkc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cclt_pkg::M_NORMAL;
      part_r <= cclt_pkg::P_KEY;
      km_r   <= cclt_pkg::KM_EMPTY;
      lkc_r  <= cclt_pkg::KIND_ORD;
    end else begin
      mode_r <= mode_nxt;
      part_r <= part_nxt;
      km_r   <= km_nxt;
      lkc_r  <= lkc_nxt;
    end
  end

endmodule

// ===== rtl/cclt_outbuf.sv =====
// Two-entry result register that drains the results of one transaction in order.
module cclt_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cclt_pkg::step_res_t step,
  output logic                can_push,
  cclt_out_if.source          out_chan
);

  cclt_pkg::res_t slot_a_r, slot_a_nxt;
  cclt_pkg::res_t slot_b_r, slot_b_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign pop      = (cnt_r != 2'd0) && out_chan.ready;
  // a new transaction may land once empty or its only result leaves this cycle
  assign can_push = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_chan.ready);

  always_comb begin
    slot_a_nxt = slot_a_r;
    slot_b_nxt = slot_b_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      slot_a_nxt = step.r0;
      slot_b_nxt = step.r1;
      cnt_nxt    = step.cnt;
    end else if (pop) begin
      slot_a_nxt = slot_b_r;
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_a_r <= slot_a_nxt;
    slot_b_r <= slot_b_nxt;
  end

  assign out_chan.valid      = (cnt_r != 2'd0);
  assign out_chan.out_char   = slot_a_r.out_char;
  assign out_chan.char_valid = slot_a_r.char_valid;
  assign out_chan.role       = slot_a_r.role;
  assign out_chan.event_res  = slot_a_r.event_res;
  assign out_chan.next_part  = slot_a_r.next_part;
  assign out_chan.line_kind  = slot_a_r.line_kind;
  assign out_chan.error_code = slot_a_r.error_code;
  assign out_chan.last       = slot_a_r.last;

endmodule

// ===== rtl/calendar_content_line_tokenizer.sv =====
// Top level of the calendar content line tokenizer.
//
// in_chan carries one raw byte (data_byte) per transaction, or an end_of_stream
// marker that flushes a pending line break or escape. out_chan carries the
// classified results: token characters with their line part, boundary events
// (key, param name, param value, line end), line kind at line end and error
// codes. One input transaction yields zero, one or two results; the final one
// of each transaction has last set.
// Results of a byte are registered and appear on out_chan in the cycle after it
// is taken. Throughput: one byte per cycle while each byte yields at most one
// result and the receiver keeps ready high; a byte with two results holds
// in_chan.ready low while the second result drains from the two-entry
// result register.
// When out_chan stalls, results are held and in_chan.ready drops as soon as
// no room is left; nothing is lost. A fatal escape halts the tokenizer: later
// bytes are taken but produce no result until reset.
// Reset (rst_n low, synchronous) returns the lexer to the key part, normal
// mode and empty result register; no clearing pass is needed.
module calendar_content_line_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  cclt_in_if.sink    in_chan,
  cclt_out_if.source out_chan
);

  cclt_pkg::step_res_t step;
  logic                can_push;
  logic                in_fire;

  assign in_chan.ready = can_push;
  assign in_fire       = in_chan.valid && can_push;

  cclt_lexer u_lexer (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (in_fire),
    .data_byte     (in_chan.data_byte),
    .end_of_stream (in_chan.end_of_stream),
    .step          (step)
  );

  cclt_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .step     (step),
    .can_push (can_push),
    .out_chan (out_chan)
  );

  // a result without last always has a follower queued behind it
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && !out_chan.last |=> out_chan.valid)
    else $error("result without last not followed by another result");

  // a transaction with two results blocks the input for the next cycle
  a_pair_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && step.cnt == 2'd2 |=> out_chan.valid && !in_chan.ready)
    else $error("input taken while a result pair is still queued");

  // token characters never carry a boundary event
  a_char_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.char_valid |-> out_chan.event_res == cclt_pkg::EV_NONE)
    else $error("token character carries a boundary event");

endmodule
